// ----- sv/mvt_pkg.sv -----
// Package for the 4x4 homogeneous matrix-vector transform.
// Holds widths, register map, reset matrix, saturation bounds and the stage-load struct.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package mvt_pkg;

    // Significant bits of an input coordinate and saturation range of a result.
    localparam int COORD_WIDTH = 32;

    localparam int FIELD_W   = 32;
    localparam int ENTRY_W   = 32;
    localparam int NUM_ROWS  = 4;
    localparam int NUM_COLS  = 4;
    localparam int PROD_W    = 2 * ENTRY_W;
    localparam int PAIR_W    = PROD_W + 1;
    localparam int SUM_W     = PROD_W + 2;
    localparam int FRAC_BITS = 16;
    localparam int SHR_W     = SUM_W - FRAC_BITS;

    // Configuration register map: eight 64-bit registers at byte address 8*i.
    localparam int NUM_REGS   = 8;
    localparam int REG_W      = 64;
    localparam int BYTE_SHIFT = 3;
    localparam int IDX_W      = $clog2(NUM_REGS);
    localparam int ADDR_W     = IDX_W + BYTE_SHIFT;

    typedef logic [REG_W-1:0]                  cfg_reg_t;
    typedef logic [NUM_REGS-1:0][REG_W-1:0]    matrix_t;
    typedef logic [1:0][REG_W-1:0]             row_regs_t;
    typedef logic [NUM_COLS-1:0][FIELD_W-1:0]  coords_t;

    localparam cfg_reg_t ONE_LOW  = cfg_reg_t'(64'h0000_0000_0001_0000);
    localparam cfg_reg_t ONE_HIGH = cfg_reg_t'(64'h0001_0000_0000_0000);

    // Identity matrix: 1.0 on the diagonal.
    localparam matrix_t MAT_RESET = {ONE_HIGH, cfg_reg_t'(0),
                                     ONE_LOW,  cfg_reg_t'(0),
                                     cfg_reg_t'(0), ONE_HIGH,
                                     cfg_reg_t'(0), ONE_LOW};

    // Saturation bounds of the shifted sum, and the same bounds as result fields.
    localparam logic signed [SHR_W-1:0] SAT_MAX =
        SHR_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SHR_W-1:0] SAT_MIN = -SAT_MAX - SHR_W'(1);
    localparam logic [FIELD_W-1:0] SAT_MAX_OUT = SAT_MAX[FIELD_W-1:0];
    localparam logic [FIELD_W-1:0] SAT_MIN_OUT = SAT_MIN[FIELD_W-1:0];

    // Per-stage load enables of the datapath pipeline.
    typedef struct packed {
        logic s1;   // products
        logic s2;   // pair sums
        logic s3;   // row sums
        logic s4;   // saturated result
    } stage_ld_t;

    // Keep the low COORD_WIDTH bits of a coordinate and sign-extend them.
    function automatic logic [FIELD_W-1:0] sext_coord(input logic [FIELD_W-1:0] v);
        return FIELD_W'($signed(v[COORD_WIDTH-1:0]));
    endfunction

endpackage

`default_nettype wire

// ----- sv/mvt_intf.sv -----
// Stream interfaces of the matrix-vector transform: point beats in, result beats out.
// Depends on mvt_pkg for field widths.
`default_nettype none

interface mvt_point_if;
    logic                               valid;
    logic                               ready;
    logic signed [mvt_pkg::FIELD_W-1:0] in_x;
    logic signed [mvt_pkg::FIELD_W-1:0] in_y;
    logic signed [mvt_pkg::FIELD_W-1:0] in_z;
    logic signed [mvt_pkg::FIELD_W-1:0] in_w;

    modport source (output valid, output in_x, output in_y, output in_z, output in_w,
                    input ready);
    modport sink   (input valid, input in_x, input in_y, input in_z, input in_w,
                    output ready);
endinterface

interface mvt_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [mvt_pkg::FIELD_W-1:0] out_x;
    logic signed [mvt_pkg::FIELD_W-1:0] out_y;
    logic signed [mvt_pkg::FIELD_W-1:0] out_z;
    logic signed [mvt_pkg::FIELD_W-1:0] out_w;
    logic                               overflow;

    modport source (output valid, output out_x, output out_y, output out_z, output out_w,
                    output overflow, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z, input out_w,
                    input overflow, output ready);
endinterface

`default_nettype wire

// ----- sv/mvt_cfg.sv -----
// APB register file holding the 4x4 transform matrix, two entries per 64-bit register.
// Depends on mvt_pkg for the register map and the identity reset value.
`default_nettype none

module mvt_cfg (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [mvt_pkg::ADDR_W-1:0] paddr,
    input  wire logic [mvt_pkg::REG_W-1:0]  pwdata,
    output logic      [mvt_pkg::REG_W-1:0]  prdata,
    output logic                            pready,
    output mvt_pkg::matrix_t                matrix
);

    mvt_pkg::matrix_t                matrix_reg;
    logic [mvt_pkg::IDX_W-1:0]       idx;
    logic                            wr_en;

    assign idx   = paddr[mvt_pkg::ADDR_W-1:mvt_pkg::BYTE_SHIFT];
    assign wr_en = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_reg <= mvt_pkg::MAT_RESET;
        end
        else if (wr_en)
        begin
            matrix_reg[idx] <= pwdata;
        end
    end

    assign prdata = matrix_reg[idx];
    assign pready = 1'b1;
    assign matrix = matrix_reg;

endmodule

`default_nettype wire

// ----- sv/mvt_lane.sv -----
// One row lane: four products, two pair sums and the full-precision row sum, pipelined.
// Depends on mvt_pkg for widths and the stage-load struct.
`default_nettype none

module mvt_lane (
    input  wire logic                              clk,
    input  wire mvt_pkg::stage_ld_t                ld,
    input  wire mvt_pkg::row_regs_t                row_regs,
    input  wire mvt_pkg::coords_t                  coords,
    output logic signed [mvt_pkg::SUM_W-1:0]       sum
);

    logic signed [mvt_pkg::PROD_W-1:0] prod_next [mvt_pkg::NUM_COLS];
    logic signed [mvt_pkg::PROD_W-1:0] prod_reg  [mvt_pkg::NUM_COLS];
    logic signed [mvt_pkg::PAIR_W-1:0] pair_next [2];
    logic signed [mvt_pkg::PAIR_W-1:0] pair_reg  [2];
    logic signed [mvt_pkg::SUM_W-1:0]  sum_next;
    logic signed [mvt_pkg::SUM_W-1:0]  sum_reg;

    // Stage 1: one 32x32 signed multiplier per column.
    for (genvar c = 0; c < mvt_pkg::NUM_COLS; c++)
    begin : g_col
        logic signed [mvt_pkg::ENTRY_W-1:0] entry;
        logic signed [mvt_pkg::FIELD_W-1:0] coord;

        assign entry = $signed(row_regs[c / 2][mvt_pkg::ENTRY_W * (c % 2) +: mvt_pkg::ENTRY_W]);
        assign coord = $signed(coords[c]);
        assign prod_next[c] = entry * coord;

        always_ff @(posedge clk)
        begin
            if (ld.s1)
            begin
                prod_reg[c] <= prod_next[c];
            end
        end
    end

    // Stage 2: pairwise sums, one bit of growth each.
    for (genvar p = 0; p < 2; p++)
    begin : g_pair
        assign pair_next[p] = mvt_pkg::PAIR_W'(prod_reg[2 * p])
                            + mvt_pkg::PAIR_W'(prod_reg[2 * p + 1]);

        always_ff @(posedge clk)
        begin
            if (ld.s2)
            begin
                pair_reg[p] <= pair_next[p];
            end
        end
    end

    // Stage 3: exact row sum.
    assign sum_next = mvt_pkg::SUM_W'(pair_reg[0]) + mvt_pkg::SUM_W'(pair_reg[1]);

    always_ff @(posedge clk)
    begin
        if (ld.s3)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

`default_nettype wire

// ----- sv/mvt_merge.sv -----
// Merge stage: floors each row sum by 16 bits, saturates it and ORs the overflow flags.
// Depends on mvt_pkg for widths and saturation bounds; holds the result register.
`default_nettype none

module mvt_merge (
    input  wire logic                                          clk,
    input  wire mvt_pkg::stage_ld_t                            ld,
    input  wire logic signed [mvt_pkg::NUM_ROWS-1:0][mvt_pkg::SUM_W-1:0] sums,
    output mvt_pkg::coords_t                                   coords,
    output logic                                               overflow
);

    mvt_pkg::coords_t                coords_next;
    mvt_pkg::coords_t                coords_reg;
    logic [mvt_pkg::NUM_ROWS-1:0]    sat;
    logic                            overflow_next;
    logic                            overflow_reg;

    for (genvar r = 0; r < mvt_pkg::NUM_ROWS; r++)
    begin : g_row
        logic signed [mvt_pkg::SHR_W-1:0] shr;
        logic                             hi;
        logic                             lo;

        // Dropping the fraction bits is the arithmetic shift (a floor).
        assign shr = $signed(sums[r][mvt_pkg::SUM_W-1:mvt_pkg::FRAC_BITS]);
        assign hi  = shr > mvt_pkg::SAT_MAX;
        assign lo  = shr < mvt_pkg::SAT_MIN;

        always_comb
        begin
            if (hi)
            begin
                coords_next[r] = mvt_pkg::SAT_MAX_OUT;
            end
            else if (lo)
            begin
                coords_next[r] = mvt_pkg::SAT_MIN_OUT;
            end
            else
            begin
                coords_next[r] = shr[mvt_pkg::FIELD_W-1:0];
            end
        end

        assign sat[r] = hi | lo;
    end

    assign overflow_next = |sat;

    always_ff @(posedge clk)
    begin
        if (ld.s4)
        begin
            coords_reg   <= coords_next;
            overflow_reg <= overflow_next;
        end
    end

    assign coords   = coords_reg;
    assign overflow = overflow_reg;

endmodule

`default_nettype wire

// ----- sv/matrix_vector_transform_4x4.sv -----
// Top level of the 4x4 homogeneous matrix-vector transform in signed Q16.16.
// Depends on mvt_pkg, the stream interfaces, mvt_cfg, mvt_lane and mvt_merge.
//
// Each point beat (x, y, z, w) is multiplied by the 4x4 matrix held in eight 64-bit
// APB registers (register i at byte address 8*i, entry of the lower column in bits
// 31:0), which reset to the identity. Four row lanes run side by side, one per result
// coordinate; each lane has four 32x32 multipliers and forms the exact sum of its four
// products. A merge stage floors each sum by 16 bits, saturates it to the signed
// coordinate range, and raises overflow if any coordinate was clamped. The block takes
// one point every cycle unless the input stalls, and a result beat is offered once its
// saturated result is registered: the products are registered at the accepting edge,
// then the pair sums, the row sums and the saturated result in turn. Every stage carries
// its own valid bit and loads whenever it is empty or its successor moves, so bubbles
// collapse and a point is still accepted while a finished result waits on the output;
// the input stalls only when all four stages are full. The matrix should be written
// only while no beat is in flight.
`default_nettype none

module matrix_vector_transform_4x4 (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    mvt_point_if.sink                       point,
    mvt_result_if.source                    result,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [mvt_pkg::ADDR_W-1:0] paddr,
    input  wire logic [mvt_pkg::REG_W-1:0]  pwdata,
    output logic      [mvt_pkg::REG_W-1:0]  prdata,
    output logic                            pready
);

    mvt_pkg::matrix_t    matrix;
    mvt_pkg::coords_t    coords_in;
    mvt_pkg::coords_t    coords_out;
    mvt_pkg::stage_ld_t  ld;
    logic                overflow;
    logic signed [mvt_pkg::NUM_ROWS-1:0][mvt_pkg::SUM_W-1:0] sums;

    // Valid bits of the four stages; bit 3 is the output register.
    logic [3:0] vld_reg;
    logic [3:0] vld_next;

    mvt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .matrix  (matrix)
    );

    // Narrow coordinate widths keep only the low bits of each input field.
    assign coords_in[0] = mvt_pkg::sext_coord(point.in_x);
    assign coords_in[1] = mvt_pkg::sext_coord(point.in_y);
    assign coords_in[2] = mvt_pkg::sext_coord(point.in_z);
    assign coords_in[3] = mvt_pkg::sext_coord(point.in_w);

    // A stage loads when it is empty or when the stage after it loads.
    always_comb
    begin
        ld.s4 = ~vld_reg[3] | result.ready;
        ld.s3 = ~vld_reg[2] | ld.s4;
        ld.s2 = ~vld_reg[1] | ld.s3;
        ld.s1 = ~vld_reg[0] | ld.s2;

        vld_next = vld_reg;
        if (ld.s1)
        begin
            vld_next[0] = point.valid;
        end
        if (ld.s2)
        begin
            vld_next[1] = vld_reg[0];
        end
        if (ld.s3)
        begin
            vld_next[2] = vld_reg[1];
        end
        if (ld.s4)
        begin
            vld_next[3] = vld_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    for (genvar r = 0; r < mvt_pkg::NUM_ROWS; r++)
    begin : g_lane
        mvt_lane u_lane (
            .clk      (clk),
            .ld       (ld),
            .row_regs ({matrix[2 * r + 1], matrix[2 * r]}),
            .coords   (coords_in),
            .sum      (sums[r])
        );
    end

    mvt_merge u_merge (
        .clk      (clk),
        .ld       (ld),
        .sums     (sums),
        .coords   (coords_out),
        .overflow (overflow)
    );

    assign point.ready     = ld.s1;
    assign result.valid    = vld_reg[3];
    assign result.out_x    = $signed(coords_out[0]);
    assign result.out_y    = $signed(coords_out[1]);
    assign result.out_z    = $signed(coords_out[2]);
    assign result.out_w    = $signed(coords_out[3]);
    assign result.overflow = overflow;

endmodule

`default_nettype wire

// ----- sv/mvt_checker.sv -----
// Port-level checks of the matrix-vector transform, attached to the top level by bind.
// Depends on mvt_pkg for the saturation bounds and on matrix_vector_transform_4x4.
`default_nettype none

module mvt_sva_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        pt_ready,
    input wire logic                        res_valid,
    input wire logic                        res_ready,
    input wire logic [mvt_pkg::FIELD_W-1:0] res_x,
    input wire logic [mvt_pkg::FIELD_W-1:0] res_y,
    input wire logic [mvt_pkg::FIELD_W-1:0] res_z,
    input wire logic [mvt_pkg::FIELD_W-1:0] res_w,
    input wire logic                        res_overflow
);

    logic any_bound;

    assign any_bound = (res_x == mvt_pkg::SAT_MAX_OUT) || (res_x == mvt_pkg::SAT_MIN_OUT)
                    || (res_y == mvt_pkg::SAT_MAX_OUT) || (res_y == mvt_pkg::SAT_MIN_OUT)
                    || (res_z == mvt_pkg::SAT_MAX_OUT) || (res_z == mvt_pkg::SAT_MIN_OUT)
                    || (res_w == mvt_pkg::SAT_MAX_OUT) || (res_w == mvt_pkg::SAT_MIN_OUT);

    // A stalled result beat stays offered.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result beat withdrawn while stalled");

    // A stalled result beat keeps its payload.
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable({res_x, res_y, res_z, res_w, res_overflow}))
        else $error("result payload changed while stalled");

    // Points are refused only while the output itself is stalled.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !pt_ready |-> res_valid && !res_ready)
        else $error("point refused without output backpressure");

    // An overflow flag comes with at least one coordinate clamped to a bound.
    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_overflow |-> any_bound)
        else $error("overflow set with no saturated coordinate");

endmodule

bind matrix_vector_transform_4x4 mvt_sva_checker u_mvt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pt_ready     (point.ready),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res_x        (result.out_x),
    .res_y        (result.out_y),
    .res_z        (result.out_z),
    .res_w        (result.out_w),
    .res_overflow (result.overflow)
);

`default_nettype wire

// ----- tb/mvt_checker.sv -----
// Checker for the 4x4 matrix-vector transform. It mirrors the matrix registers from the APB port,
// predicts every result beat from the accepted point beats and compares the two field by field.
// Depends on mvt_pkg and the stream interfaces of mvt_intf.sv.
`timescale 1ns / 1ps

module mvt_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    mvt_point_if                       point,
    mvt_result_if                      result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mvt_pkg::ADDR_W-1:0] paddr,
    input  logic [mvt_pkg::REG_W-1:0]  pwdata,
    input  logic [mvt_pkg::REG_W-1:0]  prdata,
    input  logic                       pready,
    output int                         mismatch_count,
    output int                         results_due
);

    localparam int CW = mvt_pkg::COORD_WIDTH;
    localparam logic signed [67:0] COORD_MAX = (68'sd1 <<< (CW - 1)) - 68'sd1;
    localparam logic signed [67:0] COORD_MIN = -COORD_MAX - 68'sd1;
    localparam logic [31:0] Q_ONE = 32'h0001_0000;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] w;
        logic        overflow;
    } xform_t;

    logic [mvt_pkg::NUM_REGS-1:0][mvt_pkg::REG_W-1:0] matrix_regs;
    xform_t                                           pending_results[$];

    // Entry (r, c) lives in register 2r + c/2, lower column in the low half.
    function automatic xform_t transform_point(input logic [3:0][31:0] pt);
        logic signed [67:0]   acc;
        logic signed [67:0]   floored;
        logic signed [63:0]   entry;
        logic signed [63:0]   coord;
        logic signed [CW-1:0] low_bits;
        logic [3:0][31:0]     outv;
        xform_t               res;
        res.overflow = 1'b0;
        for (int r = 0; r < 4; r++)
        begin
            acc = '0;
            for (int c = 0; c < 4; c++)
            begin
                entry    = $signed(matrix_regs[2*r + c/2][32*(c%2) +: 32]);
                low_bits = pt[c][CW-1:0];
                coord    = low_bits;
                acc      = acc + entry * coord;
            end
            floored = acc >>> mvt_pkg::FRAC_BITS;
            if (floored > COORD_MAX)
            begin
                floored      = COORD_MAX;
                res.overflow = 1'b1;
            end
            else if (floored < COORD_MIN)
            begin
                floored      = COORD_MIN;
                res.overflow = 1'b1;
            end
            outv[r] = floored[31:0];
        end
        res.x = outv[0];
        res.y = outv[1];
        res.z = outv[2];
        res.w = outv[3];
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        xform_t got;
        xform_t want;
        int     idx;
        if (!rst_n)
        begin
            matrix_regs = '0;
            for (int r = 0; r < 4; r++)
                matrix_regs[2*r + r/2][32*(r%2) +: 32] = Q_ONE;
            pending_results.delete();
            mismatch_count = 0;
            results_due <= 0;
        end
        else
        begin
            if (point.valid && point.ready)
                pending_results.push_back(transform_point({point.in_w, point.in_z,
                                                           point.in_y, point.in_x}));
            if (result.valid && result.ready)
            begin
                got = '{result.out_x, result.out_y, result.out_z, result.out_w, result.overflow};
                if (pending_results.size() == 0)
                begin
                    $display("%0t ns: result beat with no point waiting, expected none, actual %h",
                             $time, got);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("out_x", want.x, got.x);
                    check_field("out_y", want.y, got.y);
                    check_field("out_z", want.z, got.z);
                    check_field("out_w", want.w, got.w);
                    check_field("overflow", 32'(want.overflow), 32'(got.overflow));
                end
            end
            if (psel && penable && pready)
            begin
                idx = int'(paddr >> mvt_pkg::BYTE_SHIFT);
                if (idx < mvt_pkg::NUM_REGS)
                begin
                    if (pwrite)
                        matrix_regs[idx] = pwdata;
                    else if (prdata !== matrix_regs[idx])
                    begin
                        $display("%0t ns: register %0d readback, expected %h, actual %h",
                                 $time, idx, matrix_regs[idx], prdata);
                        mismatch_count++;
                    end
                end
            end
            results_due <= pending_results.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// Top of the testbench for the 4x4 matrix-vector transform: clock, reset, APB matrix loads,
// point stimulus with random gaps, result back-pressure and the final verdict.
// Depends on mvt_pkg, mvt_intf.sv, the block itself and tb/mvt_checker.sv.
`timescale 1ns / 1ps

module tb_top;

    // Register indexes of the matrix, two Q16.16 entries per 64-bit register.
    localparam int ROW0_COLS01 = 0;
    localparam int ROW0_COLS23 = 1;
    localparam int ROW1_COLS01 = 2;
    localparam int ROW1_COLS23 = 3;
    localparam int ROW2_COLS01 = 4;
    localparam int ROW2_COLS23 = 5;
    localparam int ROW3_COLS01 = 6;
    localparam int ROW3_COLS23 = 7;

    // Multiply, pair add, row add, saturate.
    localparam int PIPE_DEPTH = 4;

    localparam int RANDOM_PHASE_BEATS = 240;
    localparam int IDLE_PERCENT       = 34;

    // A few Q16.16 values that keep coming back.
    localparam logic [31:0] Q_ONE     = 32'h0001_0000;
    localparam logic [31:0] Q_HALF    = 32'h0000_8000;
    localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN     = 32'h8000_0000;
    localparam logic [31:0] Q_NEG_LSB = 32'hFFFF_FFFF;
    localparam logic [31:0] Q_LSB     = 32'h0000_0001;

    typedef logic [3:0][3:0][31:0] mat4_t;   // [row][col]
    typedef logic [mvt_pkg::NUM_REGS-1:0][mvt_pkg::REG_W-1:0] reg_file_t;

    // Kinds of random matrix used by the random phases.
    typedef enum int {
        MAT_WIDE,      // every bit random, mostly saturating
        MAT_SMALL,     // entries within +-4.0, typical transforms
        MAT_MIXED,     // per-entry mix of wide, small and extreme values
        MAT_EXTREME,   // entries drawn from the corner values only
        MAT_AFFINE     // small 3x4 block over a bottom row of (0, 0, 0, 1.0)
    } mat_kind_e;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [mvt_pkg::ADDR_W-1:0] paddr;
    logic [mvt_pkg::REG_W-1:0]  pwdata;
    logic [mvt_pkg::REG_W-1:0]  prdata;
    logic                       pready;

    // While steady is high neither the point sender nor the result receiver idles.
    logic                       steady;
    int                         fault_count;
    int                         results_due;

    mvt_point_if  point_ch ();
    mvt_result_if result_ch ();

    matrix_vector_transform_4x4 u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .point   (point_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // The checker watches both streams and the APB port; it reports the mismatch count
    // and how many result beats are still owed by the block.
    mvt_checker u_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .point          (point_ch),
        .result         (result_ch),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .mismatch_count (fault_count),
        .results_due    (results_due)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Result back-pressure: ready drops in about a third of the cycles unless the
    // current phase runs steady.
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            result_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // The whole run ends long before this bound.
    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // One APB transfer: setup cycle, access cycle (held until pready), then idle with psel
    // low so that back-to-back transfers never lower and raise psel in one step.
    task automatic apb_transfer(input int idx, input logic is_write, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= mvt_pkg::ADDR_W'(idx << mvt_pkg::BYTE_SHIFT);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic reg_write(input int idx, input logic [63:0] value);
        apb_transfer(idx, 1'b1, value);
    endtask

    // The checker compares the read data with its own copy of the register.
    task automatic reg_read(input int idx);
        apb_transfer(idx, 1'b0, '0);
    endtask

    task automatic read_all_regs();
        for (int i = 0; i < mvt_pkg::NUM_REGS; i++)
            reg_read(i);
    endtask

    // Writes all eight registers from a row/column matrix and reads them back.
    task automatic load_matrix(input mat4_t m);
        reg_file_t regs;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                regs[2*r + c/2][32*(c%2) +: 32] = m[r][c];
        for (int i = 0; i < mvt_pkg::NUM_REGS; i++)
            reg_write(i, regs[i]);
        read_all_regs();
    endtask

    // Sends one point beat. Random gaps come first; the task returns at the rising edge
    // at which the beat is taken, with valid still high so that the next beat can follow
    // without a bubble.
    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input logic [31:0] w);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            point_ch.valid <= 1'b0;
            @(posedge clk);
        end
        point_ch.valid <= 1'b1;
        point_ch.in_x  <= x;
        point_ch.in_y  <= y;
        point_ch.in_z  <= z;
        point_ch.in_w  <= w;
        @(posedge clk);
        while (!point_ch.ready)
            @(posedge clk);
    endtask

    // Stops the point stream and waits until every result beat has come back, then lets the
    // pipeline drain, so that the matrix can be rewritten with nothing in flight. The
    // edge before the loop lets the count catch up with the last accepted beat.
    task automatic settle();
        point_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH) @(posedge clk);
    endtask

    function automatic mat4_t uniform_matrix(input logic [31:0] value);
        mat4_t m;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                m[r][c] = value;
        return m;
    endfunction

    function automatic logic [31:0] rand_extreme();
        int pick;
        pick = $urandom_range(5);
        if (pick == 0)
            return Q_MAX;
        else if (pick == 1)
            return Q_MIN;
        else if (pick == 2)
            return '0;
        else if (pick == 3)
            return Q_NEG_LSB;
        else if (pick == 4)
            return Q_ONE;
        return -Q_ONE;
    endfunction

    // Coordinates: random words most often, a good share of small values so that plenty of
    // results stay clear of saturation, plus corners, whole numbers and raw -256..255 values.
    function automatic logic [31:0] rand_coord();
        int pick;
        pick = $urandom_range(9);
        if (pick <= 3)
            return $urandom();
        else if (pick <= 6)
            return 32'($urandom_range(32'h001F_FFFF)) - 32'h0010_0000;
        else if (pick == 7)
            return rand_extreme();
        else if (pick == 8)
            return {16'($urandom()), 16'h0000};
        return 32'($urandom_range(511)) - 32'd256;
    endfunction

    function automatic logic [31:0] rand_small_entry();
        return 32'($urandom_range(32'h0007_FFFF)) - 32'h0004_0000;
    endfunction

    function automatic mat4_t rand_matrix(input mat_kind_e kind);
        mat4_t m;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
            begin
                case (kind)
                    MAT_WIDE:    m[r][c] = $urandom();
                    MAT_SMALL:   m[r][c] = rand_small_entry();
                    MAT_MIXED:   m[r][c] = rand_coord();
                    MAT_EXTREME: m[r][c] = rand_extreme();
                    default:     m[r][c] = rand_small_entry();
                endcase
            end
        if (kind == MAT_AFFINE)
            m[3] = {Q_ONE, 32'h0, 32'h0, 32'h0};
        return m;
    endfunction

    task automatic random_points(input int count);
        for (int i = 0; i < count; i++)
            send_point(rand_coord(), rand_coord(), rand_coord(), rand_coord());
        settle();
    endtask

    initial
    begin
        rst_n            = 1'b0;
        steady           = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        point_ch.valid   = 1'b0;
        point_ch.in_x    = '0;
        point_ch.in_y    = '0;
        point_ch.in_z    = '0;
        point_ch.in_w    = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The reset matrix is the identity. Read it back, then push exact boundary
        // values through it: full-scale coordinates land exactly on the limits without
        // setting overflow, and a raw -1 stays -1 after the floor.
        read_all_regs();
        send_point('0, '0, '0, '0);
        send_point(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_point(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        send_point(Q_ONE, -Q_ONE, Q_HALF, -Q_HALF);
        send_point(Q_NEG_LSB, Q_LSB, Q_MAX, Q_MIN);
        settle();

        // Every entry at the most negative value. Four products of 2^62 add up to 2^64,
        // the largest sum the datapath can see, which must clamp high; the mirrored case
        // clamps low. Single raw LSB inputs check the floor on both signs.
        load_matrix(uniform_matrix(Q_MIN));
        send_point(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        send_point(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_point(Q_LSB, '0, '0, '0);
        send_point(Q_NEG_LSB, '0, '0, '0);
        send_point(Q_ONE, -Q_ONE, '0, '0);
        settle();

        // Every entry at the most positive value: saturation both ways, a negative
        // fraction that floors away from zero, and 1.0 giving exactly the maximum.
        load_matrix(uniform_matrix(Q_MAX));
        send_point(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_point(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        send_point(Q_NEG_LSB, '0, '0, '0);
        send_point(Q_ONE, '0, '0, '0);
        settle();

        // All entries 1.0: sums one LSB beyond each limit must clamp and flag, while a
        // lone full-scale coordinate passes through unchanged.
        load_matrix(uniform_matrix(Q_ONE));
        send_point(Q_MAX, Q_LSB, '0, '0);
        send_point(Q_MIN, Q_NEG_LSB, '0, '0);
        send_point(Q_MAX, '0, '0, '0);
        settle();

        // Random phases, each with its own matrix. The small-matrix phase runs without
        // any idling so that the block also sees long back-to-back streams.
        load_matrix(rand_matrix(MAT_MIXED));
        random_points(RANDOM_PHASE_BEATS);

        load_matrix(rand_matrix(MAT_SMALL));
        steady = 1'b1;
        random_points(RANDOM_PHASE_BEATS);
        steady = 1'b0;

        // Wide random matrix, then one register rewritten on its own so that a single
        // write between phases is covered too.
        load_matrix(rand_matrix(MAT_WIDE));
        reg_write(ROW1_COLS01, {Q_MIN, Q_MAX});
        reg_read(ROW1_COLS01);
        random_points(RANDOM_PHASE_BEATS);

        load_matrix(rand_matrix(MAT_AFFINE));
        random_points(RANDOM_PHASE_BEATS);

        load_matrix(rand_matrix(MAT_EXTREME));
        random_points(RANDOM_PHASE_BEATS);

        load_matrix(rand_matrix(MAT_MIXED));
        random_points(RANDOM_PHASE_BEATS);

        // A zero matrix must give zero results whatever the point.
        load_matrix(uniform_matrix('0));
        random_points(10);

        if (fault_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
